/* src/bdq_pkg.sv */
package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int ACT_W   = 3;
    localparam int COUNT_W = 5;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [FILL_W-1:0]        t_fill;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [COUNT_W-1:0]       t_count;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_FIND       = 3'd4,
        ACT_ERASE      = 3'd5,
        ACT_CLEAR      = 3'd6
    } t_action;

    typedef struct packed {
        logic  put_front;
        logic  put_back;
        logic  pop_front;
        logic  erase;
        t_word value;
    } t_cell_ctl;

endpackage

/* src/bdq_if.sv */
interface bdq_req_if import bdq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    t_word              value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   ok;
    t_word  popped;
    t_count count;

    modport source (output valid, output ok, output popped, output count, input ready);
    modport sink   (input valid, input ok, input popped, input count, output ready);
endinterface

/* src/bdq_cell.sv */
module bdq_cell import bdq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_left,
    input  t_word     i_right,
    input  logic      i_occ,
    input  logic      i_tail,
    input  logic      i_seen,
    output t_word     o_data,
    output logic      o_match
);

    t_word r_data;
    t_word n_data;
    logic  w_shift_left;

    assign o_data  = r_data;
    assign o_match = i_occ && (r_data == i_ctl.value);

    // erase: this cell and every one after the first hit pulls from the right
    assign w_shift_left = i_ctl.pop_front || (i_ctl.erase && (i_seen || o_match));

    always_comb begin
        n_data = r_data;
        if (i_ctl.put_front) begin
            n_data = i_left;
        end else if (i_ctl.put_back && i_tail) begin
            n_data = i_ctl.value;
        end else if (w_shift_left) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

/* src/bounded_deque_with_search_top.sv */
// Bounded deque with search and erase, held in a row of DEPTH cells.
// Request channel i_req: action (push front/back, pop front/back, find,
// erase, clear) and a signed 32-bit value. Response channel o_rsp: ok,
// popped (zero unless a pop succeeded) and count after the request.
// Every accepted request yields exactly one response word.
// The response is registered and shows in the cycle after the request is
// accepted. Throughput: one request per cycle while responses are taken;
// all cells compare against the value in parallel, hit flags ripple through
// the row to the first match; all shifting cells load from neighbors at once.
// Ready is high while the response register is empty or being taken, so a
// stalled receiver holds the response and blocks further requests; the
// list is never changed by a request that is not accepted.
// Reset (synchronous, active low) empties the list and drops any pending
// response; cell contents are not cleared and are never read past count.
// Push to a full list, pop from an empty one, and find/erase without a
// match return ok low and leave the list unchanged.
module bounded_deque_with_search_top import bdq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdq_req_if.sink    i_req,
    bdq_rsp_if.source  o_rsp
);

    t_fill     r_fill;
    t_fill     n_fill;
    logic      r_out_valid;
    logic      r_ok;
    logic      n_ok;
    t_word     r_popped;
    t_word     n_popped;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    logic      w_hit;
    t_action   w_act;
    t_cell_ctl w_ctl;
    t_idx      w_back_idx;

    t_word     w_data [DEPTH];
    logic      w_match [DEPTH];
    logic      w_seen [DEPTH+1];

    assign w_accept = i_req.valid && i_req.ready;
    assign w_full   = (r_fill == t_fill'(DEPTH));
    assign w_empty  = (r_fill == '0);
    assign w_act    = t_action'(i_req.action);
    assign w_hit    = w_seen[DEPTH];

    assign i_req.ready  = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.ok     = r_ok;
    assign o_rsp.popped = r_popped;
    assign o_rsp.count  = t_count'(r_fill);

    always_comb begin
        w_ctl.put_front = w_accept && (w_act == ACT_PUSH_FRONT) && !w_full;
        w_ctl.put_back  = w_accept && (w_act == ACT_PUSH_BACK) && !w_full;
        w_ctl.pop_front = w_accept && (w_act == ACT_POP_FRONT) && !w_empty;
        w_ctl.erase     = w_accept && (w_act == ACT_ERASE);
        w_ctl.value     = i_req.value;
    end

    assign w_seen[0] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_word w_left;
        t_word w_right;
        logic  w_occ;
        logic  w_tail;

        assign w_occ  = (t_fill'(gi) < r_fill);
        assign w_tail = (t_fill'(gi) == r_fill);

        if (gi == 0) begin : g_head
            assign w_left = i_req.value;
        end else begin : g_mid
            assign w_left = w_data[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_data[gi];
        end else begin : g_inner
            assign w_right = w_data[gi+1];
        end

        assign w_seen[gi+1] = w_seen[gi] || w_match[gi];

        bdq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_occ   (w_occ),
            .i_tail  (w_tail),
            .i_seen  (w_seen[gi]),
            .o_data  (w_data[gi]),
            .o_match (w_match[gi])
        );
    end

    assign w_back_idx = t_idx'(r_fill - t_fill'(1));

    always_comb begin
        n_fill   = r_fill;
        n_ok     = 1'b0;
        n_popped = '0;
        case (w_act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (!w_full) begin
                    n_fill = r_fill + t_fill'(1);
                    n_ok   = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (!w_empty) begin
                    n_fill   = r_fill - t_fill'(1);
                    n_ok     = 1'b1;
                    n_popped = w_data[0];
                end
            end
            ACT_POP_BACK: begin
                if (!w_empty) begin
                    n_fill   = r_fill - t_fill'(1);
                    n_ok     = 1'b1;
                    n_popped = w_data[w_back_idx];
                end
            end
            ACT_FIND: begin
                n_ok = w_hit;
            end
            ACT_ERASE: begin
                if (w_hit) begin
                    n_fill = r_fill - t_fill'(1);
                    n_ok   = 1'b1;
                end
            end
            ACT_CLEAR: begin
                n_fill = '0;
                n_ok   = 1'b1;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok     <= n_ok;
            r_popped <= n_popped;
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= t_fill'(DEPTH))
        else $error("fill exceeds depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_act == ACT_CLEAR) |=> (o_rsp.valid && o_rsp.ok && r_fill == '0))
        else $error("clear did not empty the list");

    a_full_push_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_full && (w_act == ACT_PUSH_FRONT || w_act == ACT_PUSH_BACK))
        |=> (!o_rsp.ok && $stable(r_fill)))
        else $error("push accepted on a full list");

    a_miss_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_hit && (w_act == ACT_FIND || w_act == ACT_ERASE))
        |=> (!o_rsp.ok && $stable(r_fill)))
        else $error("search miss changed the list");
`endif

endmodule
